// File: hw/rtl/mqs_pkg.sv
// Shared types and codes of the two-stack maximum queue.
`timescale 1ns / 1ps
`default_nettype none
package mqs_pkg;

   // Operation codes of a request transaction.
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // Status codes of a response transaction.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Request transaction payload.
   typedef struct packed {
      logic               func;
      logic signed [31:0] data_in;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic signed [31:0] max_value;
      logic               max_valid;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic push_in;
      logic xfer;
      logic pop_rd;
      logic pop_wb;
      logic set_full;
      logic set_empty;
      logic resp;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic func;
      logic in_full;
      logic in_empty;
      logic out_empty;
   } dp_stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/max_queue_two_stacks.sv
// Top level of the FIFO with running maximum, built from two maximum-tracking stacks.
//
//  Channel   Ports                          Direction  Handshake
//  request   start, busy, req_data          in         accepted when start and not busy
//  response  rsp_strobe, rsp_data           out        one-cycle strobe, cannot be held off
//
// An enqueue passes through the accept, decide and response states before the next acceptance.
// A dequeue from a non-empty outbox passes through the accept, decide, pop, pop write-back and
// response states; one that finds the outbox empty first runs a transfer state that moves one
// word a cycle through the registered read port of the inbox memory until the inbox drains.
// Reset clears both stack counts; no memory clearing pass is needed.
// A new transaction may be accepted in the cycle in which the previous response is strobed.
`timescale 1ns / 1ps
`default_nettype none
module max_queue_two_stacks #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mqs_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output mqs_pkg::rsp_type      rsp_data
);

   mqs_pkg::ctl_cmd_type cmd;
   mqs_pkg::dp_stat_type stat;

   // Stacks, memories and response register.
   mqs_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // Sequencing of each transaction.
   mqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

endmodule
`default_nettype wire

// File: hw/rtl/mqs_datapath.sv
// Datapath of the maximum queue: both stacks, their memories and the response register.
`timescale 1ns / 1ps
`default_nettype none
module mqs_datapath #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mqs_pkg::req_type    req_data,
   input  wire mqs_pkg::ctl_cmd_type cmd,
   output mqs_pkg::dp_stat_type     stat,
   output mqs_pkg::rsp_type         rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = 2 * DATA_WIDTH;

   // Latched request.
   logic                         func_ff;
   logic signed [DATA_WIDTH-1:0] din_ff;

   // Stack control: entry counts and cached maxima.
   logic [CW-1:0]                in_count_ff, in_count_in;
   logic [CW-1:0]                out_count_ff, out_count_in;
   logic signed [DATA_WIDTH-1:0] in_max_ff, in_max_in;
   logic signed [DATA_WIDTH-1:0] out_max_ff, out_max_in;
   logic                         pend_ff, pend_in;

   // Result holding registers.
   logic [1:0]                   status_ff;
   logic signed [DATA_WIDTH-1:0] dout_ff;
   mqs_pkg::rsp_type             rsp_ff;

   // Memories: each entry holds the maximum below it and the value itself.
   logic [EW-1:0]                in_mem [DEPTH];
   logic [EW-1:0]                out_mem [DEPTH];
   logic [EW-1:0]                in_rd_ff, out_rd_ff;

   logic [CW-1:0]                in_top_c, out_top_c;
   logic [AW-1:0]                in_waddr, in_raddr, out_waddr, out_raddr;
   logic                         in_we, in_re, out_we, out_re;
   logic [EW-1:0]                in_wdata, out_wdata;
   logic signed [DATA_WIDTH-1:0] xfer_val, pop_val, pop_prev;
   logic                         in_nonempty, out_nonempty;
   logic signed [DATA_WIDTH-1:0] mx;

   assign in_nonempty  = (in_count_ff != '0);
   assign out_nonempty = (out_count_ff != '0);
   assign in_top_c     = in_count_ff - CW'(1);
   assign out_top_c    = out_count_ff - CW'(1);
   assign in_waddr     = in_count_ff[AW-1:0];
   assign in_raddr     = in_top_c[AW-1:0];
   assign out_waddr    = out_count_ff[AW-1:0];
   assign out_raddr    = out_top_c[AW-1:0];
   assign xfer_val     = in_rd_ff[DATA_WIDTH-1:0];
   assign pop_val      = out_rd_ff[DATA_WIDTH-1:0];
   assign pop_prev     = out_rd_ff[EW-1:DATA_WIDTH];

   // Memory port controls.
   assign in_we     = cmd.push_in;
   assign in_wdata  = {in_max_ff, din_ff};
   assign in_re     = cmd.xfer && in_nonempty;
   assign out_we    = cmd.xfer && pend_ff;
   assign out_wdata = {out_max_ff, xfer_val};
   assign out_re    = cmd.pop_rd;

   // Status to the controller.
   assign stat.func      = func_ff;
   assign stat.in_full   = (in_count_ff == CW'(DEPTH));
   assign stat.in_empty  = !in_nonempty;
   assign stat.out_empty = !out_nonempty;

   // Next state of both stacks.
   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      in_max_in    = in_max_ff;
      out_max_in   = out_max_ff;
      pend_in      = in_re;
      if (cmd.push_in) begin
         in_count_in = in_count_ff + CW'(1);
         if (!in_nonempty || din_ff > in_max_ff) begin
            in_max_in = din_ff;
         end
      end
      if (in_re) begin
         in_count_in = in_top_c;
      end
      if (out_we) begin
         out_count_in = out_count_ff + CW'(1);
         if (!out_nonempty || xfer_val > out_max_ff) begin
            out_max_in = xfer_val;
         end
      end
      if (cmd.pop_rd) begin
         out_count_in = out_top_c;
      end
      if (cmd.pop_wb) begin
         out_max_in = pop_prev;
      end
   end

   // Queue maximum from the two stack maxima.
   always_comb begin
      mx = '0;
      if (in_nonempty && out_nonempty) begin
         mx = (out_max_ff > in_max_ff) ? out_max_ff : in_max_ff;
      end else if (in_nonempty) begin
         mx = in_max_ff;
      end else if (out_nonempty) begin
         mx = out_max_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         pend_ff      <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_max_ff  <= in_max_in;
      out_max_ff <= out_max_in;
      if (cmd.accept) begin
         func_ff   <= req_data.func;
         din_ff    <= DATA_WIDTH'(req_data.data_in);
         status_ff <= mqs_pkg::ST_OK;
         dout_ff   <= '0;
      end
      if (cmd.set_full) begin
         status_ff <= mqs_pkg::ST_FULL;
      end
      if (cmd.set_empty) begin
         status_ff <= mqs_pkg::ST_EMPTY;
      end
      if (cmd.pop_wb) begin
         dout_ff <= pop_val;
      end
      if (cmd.resp) begin
         rsp_ff.status    <= status_ff;
         rsp_ff.data_out  <= 32'(dout_ff);
         rsp_ff.max_value <= 32'(mx);
         rsp_ff.max_valid <= in_nonempty || out_nonempty;
      end
   end

   // Inbox memory.
   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[in_waddr] <= in_wdata;
      end
      if (in_re) begin
         in_rd_ff <= in_mem[in_raddr];
      end
   end

   // Outbox memory.
   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_waddr] <= out_wdata;
      end
      if (out_re) begin
         out_rd_ff <= out_mem[out_raddr];
      end
   end

   assign rsp_data = rsp_ff;

   // Neither stack ever holds more than its depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      in_count_ff <= CW'(DEPTH) && out_count_ff <= CW'(DEPTH))
      else $error("stack count beyond depth");

   // A transfer never overfills the outbox.
   a_xfer_room: assert property (@(posedge clock) disable iff (reset)
      cmd.xfer |-> ({1'b0, in_count_ff} + {1'b0, out_count_ff} + (CW+1)'(pend_ff)
                    <= (CW+1)'(DEPTH)))
      else $error("transfer would overflow the outbox");

   // A pop is issued only on a non-empty outbox.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |-> out_nonempty)
      else $error("pop from an empty outbox");

   // A push never lands on a full inbox.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push_in |-> in_count_ff < CW'(DEPTH))
      else $error("push onto a full inbox");

endmodule
`default_nettype wire

// File: hw/rtl/mqs_ctrl.sv
// Controller state machine of the maximum queue.
`timescale 1ns / 1ps
`default_nettype none
module mqs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_strobe,
   input  wire mqs_pkg::dp_stat_type stat,
   output mqs_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECIDE = 6'b000010,
      S_XFER   = 6'b000100,
      S_POP    = 6'b001000,
      S_POP_WB = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.func == mqs_pkg::FUNC_ENQ) begin
               if (stat.in_full) begin
                  cmd.set_full = 1'b1;
               end else begin
                  cmd.push_in = 1'b1;
               end
               state_in = S_RESP;
            end else if (!stat.out_empty) begin
               state_in = S_POP;
            end else if (!stat.in_empty) begin
               state_in = S_XFER;
            end else begin
               cmd.set_empty = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_XFER: begin
            // One inbox read and one outbox write per cycle until the inbox drains.
            cmd.xfer = 1'b1;
            if (stat.in_empty) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POP_WB;
         end
         S_POP_WB: begin
            cmd.pop_wb = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            cmd.resp = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign strobe_in  = (state_ff == S_RESP);
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // The response strobe is one cycle long; the controller issues one per accepted transaction.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   // An accepted transaction makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start work");

   // The strobe follows the response state.
   a_strobe_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_RESP))
      else $error("strobe without a response state");

endmodule
`default_nettype wire
